/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/pcrc_pkg.sv */
package pcrc_pkg;

	localparam int DEFAULT_MAX_DEGREE = 32;

	localparam int POLY_W = 32;
	localparam int DEG_W = 6;
	localparam int DEG_CMP_W = DEG_W + 1;
	localparam int REM_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W = 8;
	localparam int OUT_USER_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_POLY_LOW_BITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLY_DEGREE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHECK_MODE = 2'd2;

	localparam logic [POLY_W-1:0] POLY_RESET = 32'h0000_1021;
	localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd16;
	localparam logic CHECK_MODE_RESET = 1'b0;

	typedef struct packed {
		logic [POLY_W-1:0] poly_low_bits;
		logic [DEG_W-1:0] poly_degree;
		logic check_mode;
	} cfg_t;

endpackage

/* rtl/core/pcrc_step.sv */
module pcrc_step #(
	parameter int MAX_DEGREE = pcrc_pkg::DEFAULT_MAX_DEGREE
) (
	input pcrc_pkg::cfg_t cfg,
	input logic [MAX_DEGREE-1:0] rem,
	input logic data_bit,
	input logic msg_last,
	output logic [MAX_DEGREE-1:0] rem_next,
	output logic [pcrc_pkg::REM_W-1:0] remainder_value,
	output logic check_ok,
	output logic poly_invalid
);
	import pcrc_pkg::*;

	localparam logic [DEG_CMP_W-1:0] MAX_DEG_C = DEG_CMP_W'(MAX_DEGREE);

	logic [DEG_CMP_W-1:0] deg_ext;
	logic [DEG_CMP_W-1:0] eff_deg;
	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] top_sel;
	logic [MAX_DEGREE-1:0] poly_m;
	logic [MAX_DEGREE-1:0] rem_m;
	logic [MAX_DEGREE-1:0] shifted;
	logic top;

	assign deg_ext = {1'b0, cfg.poly_degree};

	// A degree of zero behaves as one, anything above the maximum as the maximum.
	always_comb begin
		priority if (deg_ext == '0) begin
			eff_deg = DEG_CMP_W'(1);
		end else if (deg_ext > MAX_DEG_C) begin
			eff_deg = MAX_DEG_C;
		end else begin
			eff_deg = deg_ext;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask[i] = DEG_CMP_W'(i) < eff_deg;
			top_sel[i] = DEG_CMP_W'(i + 1) == eff_deg;
		end
	end

	assign poly_m = MAX_DEGREE'(cfg.poly_low_bits) & mask;
	assign rem_m = rem & mask;
	assign top = (|(rem_m & top_sel)) ^ (~cfg.check_mode & data_bit);
	assign shifted = ((rem_m << 1) | MAX_DEGREE'(cfg.check_mode & data_bit)) & mask;
	assign rem_next = top ? (shifted ^ poly_m) : shifted;

	assign remainder_value = REM_W'(rem_next);
	assign check_ok = cfg.check_mode & msg_last & (rem_next == '0);
	assign poly_invalid = ~cfg.poly_low_bits[0];

endmodule

/* rtl/core/programmable_crc_serial.sv */
// Bit-serial CRC engine with a programmable generator polynomial of degree
// 1 to MAX_DEGREE. One message bit enters per transaction, most significant
// first, and one result leaves for every bit: the running remainder, with
// tlast copied from the input. In generate mode the remainder after the
// bit marked tlast is the check value to append; in check mode the whole
// codeword is fed in and check_ok is set on the last bit when the remainder
// is zero. The remainder clears after every last bit. A bit is accepted in
// every cycle while the output is not stalled: the single shift and xor of
// the remainder register sets that rate; the result appears from a register
// in the cycle after acceptance. The cfg port is always ready; users write
// configuration only while no bits are in flight; the block does not check.
`include "assert_macros.svh"

module programmable_crc_serial #(
	parameter int MAX_DEGREE = pcrc_pkg::DEFAULT_MAX_DEGREE
) (
	input logic clk,
	input logic arst_n,

	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [pcrc_pkg::CFG_DATA_W-1:0] cfg_data,

	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// Bit 0 data_bit, bits 7:1 zero.
	input logic [pcrc_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input logic s_axis_tlast,

	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// Bits 31:0 remainder_value.
	output logic [pcrc_pkg::REM_W-1:0] m_axis_tdata,
	// Bit 0 check_ok, bit 1 poly_invalid.
	output logic [pcrc_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic m_axis_tlast
);
	import pcrc_pkg::*;

	cfg_t cfg_q;
	logic [MAX_DEGREE-1:0] rem_q;
	logic out_valid_q;
	logic [REM_W-1:0] out_rem_q;
	logic out_ok_q;
	logic out_inv_q;
	logic out_last_q;

	logic in_acc;
	logic cfg_acc;
	logic [MAX_DEGREE-1:0] rem_next;
	logic [REM_W-1:0] remainder_value;
	logic check_ok;
	logic poly_invalid;

	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid & cfg_ready;
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign in_acc = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly_low_bits <= POLY_RESET;
			cfg_q.poly_degree <= DEGREE_RESET;
			cfg_q.check_mode <= CHECK_MODE_RESET;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_POLY_LOW_BITS: cfg_q.poly_low_bits <= cfg_data;
				REG_POLY_DEGREE: cfg_q.poly_degree <= cfg_data[DEG_W-1:0];
				REG_CHECK_MODE: cfg_q.check_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pcrc_step #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_step (
		.cfg(cfg_q),
		.rem(rem_q),
		.data_bit(s_axis_tdata[0]),
		.msg_last(s_axis_tlast),
		.rem_next(rem_next),
		.remainder_value(remainder_value),
		.check_ok(check_ok),
		.poly_invalid(poly_invalid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				rem_q <= s_axis_tlast ? '0 : rem_next;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_rem_q <= remainder_value;
			out_ok_q <= check_ok;
			out_inv_q <= poly_invalid;
			out_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_rem_q;
	assign m_axis_tuser = {out_inv_q, out_ok_q};
	assign m_axis_tlast = out_last_q;

	`ASSERT_NEXT(a_rem_clear_after_last, clk, arst_n, in_acc && s_axis_tlast, rem_q == '0)
	`ASSERT_NEXT(a_result_after_accept, clk, arst_n, in_acc, m_axis_tvalid)
	`ASSERT_SAME(a_ok_only_at_end, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

endmodule
